### hdl/cism_pkg.sv
// Shared constants, types and helper functions for the substring matcher.
package cism_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int INDEX_BITS    = 16;
  localparam int PATTERN_BYTES = 16;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int CFG_LEN_W     = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int LIMIT_W       = 16;
  localparam int START_W       = 16;
  localparam int BYTE_W        = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_LIMIT_ENABLED  = 3'd3,
    CFG_SEARCH_LIMIT   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic               string_done;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Bytes past the register pair read as zero.
  function automatic logic [BYTE_W-1:0] pattern_byte(
    input logic [PATTERN_BYTES*BYTE_W-1:0] p,
    input int                              k
  );
    logic [BYTE_W-1:0] r;
    r = '0;
    if (k >= 0 && k < PATTERN_BYTES) begin
      r = p[k*BYTE_W +: BYTE_W];
    end
    return r;
  endfunction

endpackage

### hdl/cism_cfg_if.sv
// Configuration write channel: register index and write data.
interface cism_cfg_if import cism_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/cism_text_if.sv
// Text input channel: one text byte per word.
interface cism_text_if import cism_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, text_byte, input ready);
  modport sink (input valid, text_byte, output ready);
endinterface

### hdl/cism_result_if.sv
// Result channel: match status per text word.
interface cism_result_if import cism_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;
  logic               string_done;

  modport source (output valid, match_found, match_start, string_done, input ready);
  modport sink (input valid, match_found, match_start, string_done, output ready);
endinterface

### hdl/cism_cell.sv
// One window cell: holds a folded text byte, passes it on, compares its input.
module cism_cell import cism_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] din,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              active,
  output logic [BYTE_W-1:0] q,
  output logic              hit
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= din;
    end
  end

  // din is this cell's window byte after the shift
  assign hit = !active || (din == pat_byte);

endmodule

### hdl/cism_out_buf.sv
// Output register with skid slot for the result channel.
module cism_out_buf import cism_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_word,
  output logic    in_ready,
  cism_result_if.source result
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_word;
  result_t skid_word;
  logic    drain;

  assign drain    = !out_valid || result.ready;
  assign in_ready = !skid_valid;

  assign result.valid       = out_valid;
  assign result.match_found = out_word.match_found;
  assign result.match_start = out_word.match_start;
  assign result.string_done = out_word.string_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_word <= skid_valid ? skid_word : in_word;
    end else if (in_valid) begin
      skid_word <= in_word;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !skid_valid)
    else $error("word pushed while skid slot full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result.ready |=> out_valid && !skid_valid)
    else $error("skid word not moved to output");
`endif

endmodule

### hdl/case_insensitive_substring_matcher_core.sv
// Top level: case-insensitive substring matcher over a byte stream.
// A result word is registered in the output buffer when its text word is accepted.
// Throughput: one text word per cycle unless stalled; each cell compares its input as it shifts.
// Input stalls only when the result channel backs up past the output skid slot.
// Reset (rst, synchronous): config registers, window, position and match state clear to zero.
// Configuration writes are always taken (ready tied high).
module case_insensitive_substring_matcher_core import cism_pkg::*; (
  input  logic clk,
  input  logic rst,
  cism_cfg_if.sink      cfg,
  cism_text_if.sink     text,
  cism_result_if.source result
);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [CFG_LEN_W-1:0]  pattern_length;
  logic                  limit_enabled;
  logic [LIMIT_W-1:0]    search_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      limit_enabled  <= 1'b0;
      search_limit   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_PATTERN_LOW:    pattern_low    <= cfg.data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg.data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg.data[CFG_LEN_W-1:0];
        CFG_LIMIT_ENABLED:  limit_enabled  <= cfg.data[0];
        CFG_SEARCH_LIMIT:   search_limit   <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len_eff;
  assign len_eff = (int'(pattern_length) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                        : LEN_W'(pattern_length);

  logic       buf_ready;
  logic       text_acc;
  logic       term;
  cell_ctrl_t cell_ctrl;

  assign text.ready      = buf_ready;
  assign text_acc        = text.valid && text.ready;
  assign term            = (text.text_byte == '0);
  assign cell_ctrl.shift = text_acc && !term;
  assign cell_ctrl.clear = text_acc && term;

  // cell row: link[k] is the byte entering cell k, newest at cell 0
  logic [BYTE_W-1:0]      link [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;

  assign link[0] = fold_case(text.text_byte);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic              cell_active;
    logic [BYTE_W-1:0] cell_pat;

    assign cell_active = (len_eff > LEN_W'(k));
    assign cell_pat    = fold_case(pattern_byte({pattern_high, pattern_low},
                                                int'(len_eff) - 1 - k));

    if (k < PATTERN_MAX - 1) begin : g_mid
      cism_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .din      (link[k]),
        .pat_byte (cell_pat),
        .active   (cell_active),
        .q        (link[k+1]),
        .hit      (hit[k])
      );
    end else begin : g_last
      cism_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .din      (link[k]),
        .pat_byte (cell_pat),
        .active   (cell_active),
        .q        (),
        .hit      (hit[k])
      );
    end
  end

  logic [INDEX_BITS-1:0] byte_index;
  logic [INDEX_BITS-1:0] byte_index_next;
  logic                  have_match;
  logic                  have_match_next;
  logic [INDEX_BITS-1:0] first_start;
  logic [INDEX_BITS-1:0] first_start_next;

  logic [INDEX_BITS:0]   pos_plus;
  logic                  sat;
  logic                  pos_ok;
  logic                  lim_ok;
  logic                  new_match;
  logic [INDEX_BITS-1:0] start_calc;

  assign pos_plus   = {1'b0, byte_index} + (INDEX_BITS+1)'(1);
  assign sat        = &byte_index;
  assign pos_ok     = pos_plus >= (INDEX_BITS+1)'(len_eff);
  assign lim_ok     = !limit_enabled || (32'(byte_index) < 32'(search_limit));
  assign start_calc = pos_plus[INDEX_BITS-1:0] - INDEX_BITS'(len_eff);
  assign new_match  = !have_match && !sat && (len_eff != '0) && pos_ok && lim_ok && (&hit);

  always_comb begin
    byte_index_next  = byte_index;
    have_match_next  = have_match;
    first_start_next = first_start;
    if (term) begin
      byte_index_next  = '0;
      have_match_next  = 1'b0;
      first_start_next = '0;
    end else begin
      if (new_match) begin
        have_match_next  = 1'b1;
        first_start_next = start_calc;
      end
      if (!sat) begin
        byte_index_next = pos_plus[INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      have_match  <= 1'b0;
      first_start <= '0;
    end else if (text_acc) begin
      byte_index  <= byte_index_next;
      have_match  <= have_match_next;
      first_start <= first_start_next;
    end
  end

  // terminator reports the state before clearing
  logic                  res_found;
  logic [INDEX_BITS-1:0] res_start;
  result_t               res_word;

  assign res_found            = term ? have_match : have_match_next;
  assign res_start            = term ? first_start : first_start_next;
  assign res_word.match_found = res_found;
  assign res_word.match_start = res_found ? START_W'(res_start) : '0;
  assign res_word.string_done = term;

  cism_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_acc),
    .in_word  (res_word),
    .in_ready (buf_ready),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    text_acc && term |=> byte_index == '0 && !have_match && first_start == '0)
    else $error("terminator did not clear string state");

  a_match_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(have_match) |-> $past(text_acc && term) || $past(rst))
    else $error("match dropped without terminator");

  a_start_held: assert property (@(posedge clk) disable iff (rst)
    have_match && !(text_acc && term) |=> $stable(first_start) && have_match)
    else $error("recorded match start changed");
`endif

endmodule

### dv/case_insensitive_substring_matcher_core_tb.sv
// Self-checking bench for the substring matcher: directed and random strings.
`timescale 1ns / 100ps

module case_insensitive_substring_matcher_core_tb;
  import cism_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 850;

  class match_status_model;
    logic [63:0]           pat_lo;
    logic [63:0]           pat_hi;
    logic [CFG_LEN_W-1:0]  pat_len;
    logic                  limit_on;
    logic [LIMIT_W-1:0]    limit_bytes;
    logic [BYTE_W-1:0]     window [PATTERN_MAX];
    logic [INDEX_BITS-1:0] pos;
    logic                  found;
    logic [INDEX_BITS-1:0] start;
    result_t               pending_status [$];
    int                    errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      limit_on = 1'b0;
      limit_bytes = '0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (window[k]) window[k] = '0;
      pos = '0;
      found = 1'b0;
      start = '0;
    endfunction

    function logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PATTERN_LOW: pat_lo = value;
        CFG_PATTERN_HIGH: pat_hi = value;
        CFG_PATTERN_LENGTH: pat_len = value[CFG_LEN_W-1:0];
        CFG_LIMIT_ENABLED: limit_on = value[0];
        CFG_SEARCH_LIMIT: limit_bytes = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      result_t      r;
      logic [127:0] pat;
      int           len;
      int           k;
      bit           saturated;
      bit           same;
      if (b == '0) begin
        r.match_found = found;
        r.match_start = found ? start[START_W-1:0] : '0;
        r.string_done = 1'b1;
        pending_status.push_back(r);
        clear_string();
        return;
      end
      pat = {pat_hi, pat_lo};
      len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      saturated = (pos == {INDEX_BITS{1'b1}});
      for (k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = to_lower(b);
      if (!found && !saturated && len != 0 && int'(pos) + 1 >= len &&
          !(limit_on && pos >= limit_bytes)) begin
        same = 1'b1;
        for (k = 0; k < len; k++) begin
          if (window[k] != to_lower(pat[(len-1-k)*BYTE_W +: BYTE_W])) same = 1'b0;
        end
        if (same) begin
          found = 1'b1;
          start = INDEX_BITS'(int'(pos) + 1 - len);
        end
      end
      if (!saturated) pos = pos + 1'b1;
      r.match_found = found;
      r.match_start = found ? start[START_W-1:0] : '0;
      r.string_done = 1'b0;
      pending_status.push_back(r);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      if (got.match_found !== want.match_found) begin
        $display("%0t: match_found expected %0b actual %0b", $time,
                 want.match_found, got.match_found);
        errors++;
      end
      if (got.match_start !== want.match_start) begin
        $display("%0t: match_start expected %0d actual %0d", $time,
                 want.match_start, got.match_start);
        errors++;
      end
      if (got.string_done !== want.string_done) begin
        $display("%0t: string_done expected %0b actual %0b", $time,
                 want.string_done, got.string_done);
        errors++;
      end
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cism_cfg_if    cfg_bus ();
  cism_text_if   text_bus ();
  cism_result_if status_bus ();

  case_insensitive_substring_matcher_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .text   (text_bus),
    .result (status_bus)
  );

  match_status_model tracker = new();
  result_t           seen;
  bit                idle_on;
  int                words_sent;
  int                cycle_count;
  logic [BYTE_W-1:0] pat_bytes [PATTERN_MAX];
  int                pat_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL case_insensitive_substring_matcher_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    status_bus.ready <= !idle_on || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        tracker.write_reg(cfg_index_t'(cfg_bus.index), cfg_bus.data);
      end
      if (text_bus.valid && text_bus.ready) begin
        tracker.note_byte(text_bus.text_byte);
      end
      if (status_bus.valid && status_bus.ready) begin
        seen.match_found = status_bus.match_found;
        seen.match_start = status_bus.match_start;
        seen.string_done = status_bus.string_done;
        tracker.check_status(seen);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    text_bus.valid <= 1'b1;
    text_bus.text_byte <= b;
    do @(posedge clk); while (!text_bus.ready);
    words_sent++;
    while (idle_on && $urandom_range(99) < 36) begin
      text_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic wait_for_results();
    text_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic load_config(input logic [127:0] pat, input int len, input bit en,
                             input logic [LIMIT_W-1:0] lim);
    int k;
    for (k = 0; k < PATTERN_MAX; k++) pat_bytes[k] = pat[BYTE_W*k +: BYTE_W];
    pat_used = (len > PATTERN_MAX) ? PATTERN_MAX : len;
    write_reg(CFG_PATTERN_LOW, pat[63:0]);
    write_reg(CFG_PATTERN_HIGH, pat[127:64]);
    write_reg(CFG_PATTERN_LENGTH, 64'(len));
    write_reg(CFG_LIMIT_ENABLED, 64'(en));
    write_reg(CFG_SEARCH_LIMIT, 64'(lim));
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] random_char();
    logic [BYTE_W-1:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: c = ($urandom_range(4) == 4) ? 8'h7A
                                                      : 8'h61 + BYTE_W'($urandom_range(3));
      6: begin
        case ($urandom_range(3))
          0: c = 8'h40;
          1: c = 8'h5B;
          2: c = 8'h60;
          default: c = 8'h7B;
        endcase
      end
      default: c = BYTE_W'($urandom_range(1, 255));
    endcase
    return flip_case(c);
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] c;
    if (pat_used > 0 && $urandom_range(1)) c = flip_case(pat_bytes[$urandom_range(pat_used - 1)]);
    else c = random_char();
    return (c == 8'h00) ? 8'h7A : c;
  endfunction

  task automatic send_random_string();
    int                k;
    int                n;
    int                reps;
    logic [BYTE_W-1:0] c;
    reps = $urandom_range(1, 2);
    repeat (reps) begin
      n = $urandom_range(8);
      for (k = 0; k < n; k++) send_byte(noise_byte());
      if (pat_used > 0 && $urandom_range(99) < 80) begin
        for (k = 0; k < pat_used; k++) begin
          c = flip_case(pat_bytes[k]);
          if (c == 8'h00 || $urandom_range(99) < 4) c = noise_byte();
          send_byte(c);
        end
      end
    end
    n = $urandom_range(5);
    for (k = 0; k < n; k++) send_byte(noise_byte());
    send_byte(8'h00);
  endtask

  task automatic random_config(input int ph);
    logic [127:0]       pat;
    int                 len;
    int                 k;
    bit                 en;
    logic [LIMIT_W-1:0] lim;
    case (ph % 6)
      0: len = PATTERN_MAX;
      1: len = $urandom_range(PATTERN_MAX + 1, 31);
      2: len = 1;
      3: len = 0;
      default: len = $urandom_range(2, 12);
    endcase
    for (k = 0; k < PATTERN_MAX; k++) pat[BYTE_W*k +: BYTE_W] = random_char();
    if (len == 0) pat = '0;
    if (ph % 8 == 6) pat = '1;
    if (ph % 7 == 4 && len > 0) begin
      k = $urandom_range(((len > PATTERN_MAX) ? PATTERN_MAX : len) - 1);
      pat[BYTE_W*k +: BYTE_W] = 8'h00;
    end
    en = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: lim = '0;
      1: lim = '1;
      default: lim = LIMIT_W'($urandom_range(30));
    endcase
    if (ph % 6 == 2) begin
      en = 1'b1;
      lim = '0;
    end
    if (ph % 6 == 5) begin
      en = 1'b1;
      lim = '1;
    end
    load_config(pat, len, en, lim);
  endtask

  initial begin
    int ph;
    int random_base;
    rst <= 1'b1;
    text_bus.valid <= 1'b0;
    text_bus.text_byte <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_PATTERN_LOW;
    cfg_bus.data <= '0;
    words_sent = 0;
    pat_used = 0;
    foreach (pat_bytes[k]) pat_bytes[k] = '0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty pattern out of reset
    send_text("ab");
    send_byte(8'h00);
    wait_for_results();

    load_config(128'h6f_4c4c_6548, 5, 1'b0, '0);
    send_byte(8'h01);
    send_text("hElLo");
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_for_results();

    // match must end before byte 5
    load_config(128'h6f_4c4c_6548, 5, 1'b1, 16'd5);
    send_text("hello");
    send_byte(8'h00);
    send_text("xhello");
    send_byte(8'h00);

    random_base = words_sent;
    ph = 0;
    while (words_sent - random_base < RANDOM_WORDS) begin
      wait_for_results();
      random_config(ph);
      repeat (6) send_random_string();
      ph++;
    end

    // position counter saturation, no idling
    wait_for_results();
    idle_on = 1'b0;
    load_config(128'h6261, 2, 1'b0, '0);
    repeat (65532) send_byte("x");
    send_text("aB");
    send_byte(8'h00);
    repeat (65534) send_byte("x");
    send_text("Abab");
    send_byte(8'h00);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS case_insensitive_substring_matcher_core");
    end else begin
      $display("FAIL case_insensitive_substring_matcher_core");
    end
    $finish;
  end

endmodule

### files.f
hdl/cism_pkg.sv
hdl/cism_cfg_if.sv
hdl/cism_text_if.sv
hdl/cism_result_if.sv
hdl/cism_cell.sv
hdl/cism_out_buf.sv
hdl/case_insensitive_substring_matcher_core.sv
dv/case_insensitive_substring_matcher_core_tb.sv
